// ----- rtl/core/icmp4_to_icmp6_header_translate_macros.svh -----
// ----------------------------------------------------------------------------
// ICMPv4 to ICMPv6 header translate: assertion macros
// Concurrent checks sampled on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ICMP4_TO_ICMP6_HEADER_TRANSLATE_MACROS_SVH
`define ICMP4_TO_ICMP6_HEADER_TRANSLATE_MACROS_SVH

// Same-cycle implication.
`define I46_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("i46: same-cycle check failed");

// Next-cycle implication.
`define I46_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("i46: next-cycle check failed");

`endif

// ----- rtl/core/i46_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i46_pkg
// Types, message codes and tables of the ICMPv4 to ICMPv6 header translator.
// ----------------------------------------------------------------------------
package i46_pkg;

  localparam int PLATEAU_SLOTS_DEF = 12;
  localparam int SLOT_W            = 16;
  localparam int CNT_W             = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU_N = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAISE_MIN = 3'd4;

  // ICMPv4 types
  localparam logic [7:0] ICMP4_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] ICMP4_DEST_UNREACH  = 8'd3;
  localparam logic [7:0] ICMP4_ECHO_REQUEST  = 8'd8;
  localparam logic [7:0] ICMP4_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] ICMP4_PARAM_PROBLEM = 8'd12;

  // ICMPv4 destination unreachable codes
  localparam logic [7:0] UNR_NET          = 8'd0;
  localparam logic [7:0] UNR_HOST         = 8'd1;
  localparam logic [7:0] UNR_PROTOCOL     = 8'd2;
  localparam logic [7:0] UNR_PORT         = 8'd3;
  localparam logic [7:0] UNR_FRAG_NEEDED  = 8'd4;
  localparam logic [7:0] UNR_SRC_ROUTE    = 8'd5;
  localparam logic [7:0] UNR_NET_UNKNOWN  = 8'd6;
  localparam logic [7:0] UNR_HOST_UNKNOWN = 8'd7;
  localparam logic [7:0] UNR_ISOLATED     = 8'd8;
  localparam logic [7:0] UNR_NET_PROHIB   = 8'd9;
  localparam logic [7:0] UNR_HOST_PROHIB  = 8'd10;
  localparam logic [7:0] UNR_NET_TOS      = 8'd11;
  localparam logic [7:0] UNR_HOST_TOS     = 8'd12;
  localparam logic [7:0] UNR_ADMIN_PROHIB = 8'd13;
  localparam logic [7:0] UNR_PREC_CUTOFF  = 8'd15;

  // ICMPv4 parameter problem codes
  localparam logic [7:0] PP4_POINTER    = 8'd0;
  localparam logic [7:0] PP4_BAD_LENGTH = 8'd2;

  // ICMPv6 types and codes
  localparam logic [7:0] ICMP6_DEST_UNREACH  = 8'd1;
  localparam logic [7:0] ICMP6_PKT_TOO_BIG   = 8'd2;
  localparam logic [7:0] ICMP6_TIME_EXCEEDED = 8'd3;
  localparam logic [7:0] ICMP6_PARAM_PROBLEM = 8'd4;
  localparam logic [7:0] ICMP6_ECHO_REQUEST  = 8'd128;
  localparam logic [7:0] ICMP6_ECHO_REPLY    = 8'd129;

  localparam logic [7:0] DU6_NO_ROUTE     = 8'd0;
  localparam logic [7:0] DU6_ADMIN_PROHIB = 8'd1;
  localparam logic [7:0] DU6_PORT         = 8'd4;
  localparam logic [7:0] PP6_HDR_FIELD    = 8'd0;
  localparam logic [7:0] PP6_NEXT_HDR     = 8'd1;
  localparam logic [7:0] PTR6_NEXT_HDR    = 8'd6;

  localparam logic [7:0]        PTR_NONE     = 8'd255;
  localparam logic [SLOT_W:0]   IPV4_HDR_LEN = 17'd20;
  localparam logic [SLOT_W-1:0] MIN_MTU6     = 16'd1280;

  // IPv4 header offset to IPv6 header offset
  function automatic logic [7:0] ptr_map(input logic [7:0] p);
    logic [7:0] r;
    case (p)
      8'd0:  r = 8'd0;
      8'd1:  r = 8'd1;
      8'd2:  r = 8'd4;
      8'd3:  r = 8'd4;
      8'd8:  r = 8'd7;
      8'd9:  r = 8'd6;
      8'd12: r = 8'd8;
      8'd13: r = 8'd8;
      8'd14: r = 8'd8;
      8'd15: r = 8'd8;
      8'd16: r = 8'd24;
      8'd17: r = 8'd24;
      8'd18: r = 8'd24;
      8'd19: r = 8'd24;
      default: r = PTR_NONE;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic        drop;
    logic        is_err;
    logic [7:0]  t6;
    logic [7:0]  c6;
    logic [31:0] r6;
    logic        is_mtu;
    logic [SLOT_W-1:0] pkt;
    logic [SLOT_W-1:0] m6;
    logic [SLOT_W-1:0] m4;
  } i46_s1_t;

  typedef struct packed {
    logic        drop;
    logic        is_err;
    logic [7:0]  t6;
    logic [7:0]  c6;
    logic [31:0] r6;
    logic        is_mtu;
    logic [SLOT_W-1:0] mtu;
  } i46_s2_t;

  typedef struct packed {
    logic        verdict;
    logic        is_error_message;
    logic [7:0]  msg6_type;
    logic [7:0]  msg6_code;
    logic [31:0] icmp6_rest;
  } i46_s3_t;

endpackage

// ----- rtl/core/i46_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i46_in_if
// Input channel: one ICMPv4 header word with the side fields it needs.
// ----------------------------------------------------------------------------
interface i46_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  icmp4_type;
  logic [7:0]  icmp4_code;
  logic [31:0] icmp4_rest;
  logic [15:0] echo_identifier;
  logic [15:0] inner_total_length;
  logic [15:0] out_link_mtu;
  logic [15:0] in_link_mtu;

  modport source (
    output valid, icmp4_type, icmp4_code, icmp4_rest, echo_identifier,
           inner_total_length, out_link_mtu, in_link_mtu,
    input  ready
  );
  modport sink (
    input  valid, icmp4_type, icmp4_code, icmp4_rest, echo_identifier,
           inner_total_length, out_link_mtu, in_link_mtu,
    output ready
  );
endinterface

// ----- rtl/core/i46_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i46_out_if
// Output channel: verdict and one translated ICMPv6 header word.
// ----------------------------------------------------------------------------
interface i46_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic        is_error_message;
  logic [7:0]  msg6_type;
  logic [7:0]  msg6_code;
  logic [31:0] icmp6_rest;

  modport source (
    output valid, verdict, is_error_message, msg6_type, msg6_code, icmp6_rest,
    input  ready
  );
  modport sink (
    input  valid, verdict, is_error_message, msg6_type, msg6_code, icmp6_rest,
    output ready
  );
endinterface

// ----- rtl/core/i46_plateau_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i46_plateau_search
// First active plateau slot below the inner total length; zero if none.
// ----------------------------------------------------------------------------
module i46_plateau_search
  import i46_pkg::*;
#(
  parameter int PLATEAU_SLOTS = PLATEAU_SLOTS_DEF
) (
  input  logic [SLOT_W-1:0] slots_i [PLATEAU_SLOTS],
  input  logic [CNT_W-1:0]  count_i,
  input  logic [SLOT_W-1:0] tot_len_i,
  output logic [SLOT_W-1:0] value_o
);

  logic [CNT_W-1:0]         cnt_eff;
  logic [PLATEAU_SLOTS-1:0] hit;

  // saturate count at the slot number
  assign cnt_eff = (count_i > CNT_W'(PLATEAU_SLOTS)) ? CNT_W'(PLATEAU_SLOTS) : count_i;

  always_comb begin
    for (int i = 0; i < PLATEAU_SLOTS; i++) begin
      hit[i] = (CNT_W'(i) < cnt_eff) && (slots_i[i] < tot_len_i);
    end
  end

  // lowest hit wins: walk from the top so lower slots override
  always_comb begin
    value_o = '0;
    for (int i = PLATEAU_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        value_o = slots_i[i];
      end
    end
  end

endmodule

// ----- rtl/core/icmp4_to_icmp6_header_translate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp4_to_icmp6_header_translate
// Stateless ICMPv4 to ICMPv6 header translation with path MTU computation.
// ----------------------------------------------------------------------------
// Takes one header word per clock unless a stall has backed up to the input,
// and returns one translated word per header; the three register stages are
// decode with plateau search, MTU sums and minimum, then the optional 1280
// floor and output register. A stalled output holds every stage that
// cannot move, and stages with room keep filling. Configuration writes go
// straight to registers and should only be made while no word is in flight.
`include "icmp4_to_icmp6_header_translate_macros.svh"

module icmp4_to_icmp6_header_translate
  import i46_pkg::*;
#(
  parameter int PLATEAU_SLOTS = PLATEAU_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  i46_in_if.sink                in_i,
  i46_out_if.source             out_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SLOT_W-1:0] plateau_q [PLATEAU_SLOTS];
  logic [CNT_W-1:0]  count_q;
  logic              raise_q;

  for (genvar s = 0; s < PLATEAU_SLOTS; s++) begin : g_slot
    localparam int G = s / 4;
    localparam int L = s % 4;
    localparam logic [CFG_IDX_W-1:0] GIDX =
      (G == 0) ? CFG_PLATEAU_A : (G == 1) ? CFG_PLATEAU_B : CFG_PLATEAU_C;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        plateau_q[s] <= '0;
      end else if (cfg_we_i && (cfg_idx_i == GIDX)) begin
        plateau_q[s] <= cfg_data_i[SLOT_W*L +: SLOT_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      raise_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PLATEAU_N) begin
        count_q <= cfg_data_i[CNT_W-1:0];
      end
      if (cfg_idx_i == CFG_RAISE_MIN) begin
        raise_q <= cfg_data_i[0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic in_fire;

  assign rdy3       = !v3_q || out_o.ready;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;
  assign in_fire    = in_i.valid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: decode and plateau search
  // --------------------------------------------------------------------------
  i46_s1_t           s1_d, s1_q;
  logic [SLOT_W-1:0] plat_val;
  logic [SLOT_W-1:0] reported;
  logic [7:0]        ptr6;
  logic              drop;

  assign reported = in_i.icmp4_rest[SLOT_W-1:0];
  assign ptr6     = ptr_map(in_i.icmp4_rest[31:24]);

  i46_plateau_search #(
    .PLATEAU_SLOTS (PLATEAU_SLOTS)
  ) u_search (
    .slots_i   (plateau_q),
    .count_i   (count_q),
    .tot_len_i (in_i.inner_total_length),
    .value_o   (plat_val)
  );

  always_comb begin
    s1_d     = '0;
    drop     = 1'b0;
    s1_d.pkt = (reported == '0) ? plat_val : reported;
    s1_d.m6  = in_i.out_link_mtu;
    s1_d.m4  = in_i.in_link_mtu;
    case (in_i.icmp4_type)
      ICMP4_ECHO_REQUEST: begin
        s1_d.t6 = ICMP6_ECHO_REQUEST;
        s1_d.r6 = {in_i.echo_identifier, in_i.icmp4_rest[15:0]};
      end
      ICMP4_ECHO_REPLY: begin
        s1_d.t6 = ICMP6_ECHO_REPLY;
        s1_d.r6 = {in_i.echo_identifier, in_i.icmp4_rest[15:0]};
      end
      ICMP4_DEST_UNREACH: begin
        s1_d.is_err = 1'b1;
        s1_d.t6     = ICMP6_DEST_UNREACH;
        case (in_i.icmp4_code)
          UNR_NET, UNR_HOST, UNR_SRC_ROUTE, UNR_NET_UNKNOWN, UNR_HOST_UNKNOWN,
          UNR_ISOLATED, UNR_NET_TOS, UNR_HOST_TOS: begin
            s1_d.c6 = DU6_NO_ROUTE;
          end
          UNR_PROTOCOL: begin
            s1_d.t6 = ICMP6_PARAM_PROBLEM;
            s1_d.c6 = PP6_NEXT_HDR;
            s1_d.r6 = {24'b0, PTR6_NEXT_HDR};
          end
          UNR_PORT: begin
            s1_d.c6 = DU6_PORT;
          end
          UNR_FRAG_NEEDED: begin
            s1_d.t6     = ICMP6_PKT_TOO_BIG;
            s1_d.is_mtu = 1'b1;
          end
          UNR_NET_PROHIB, UNR_HOST_PROHIB, UNR_ADMIN_PROHIB, UNR_PREC_CUTOFF: begin
            s1_d.c6 = DU6_ADMIN_PROHIB;
          end
          default: begin
            drop = 1'b1;
          end
        endcase
      end
      ICMP4_TIME_EXCEEDED: begin
        s1_d.is_err = 1'b1;
        s1_d.t6     = ICMP6_TIME_EXCEEDED;
        s1_d.c6     = in_i.icmp4_code;
      end
      ICMP4_PARAM_PROBLEM: begin
        s1_d.is_err = 1'b1;
        s1_d.t6     = ICMP6_PARAM_PROBLEM;
        if ((in_i.icmp4_code == PP4_POINTER || in_i.icmp4_code == PP4_BAD_LENGTH)
            && (ptr6 != PTR_NONE)) begin
          s1_d.c6 = PP6_HDR_FIELD;
          s1_d.r6 = {24'b0, ptr6};
        end else begin
          drop = 1'b1;
        end
      end
      default: begin
        drop = 1'b1;
      end
    endcase
    // a dropped word carries nothing but the verdict
    if (drop) begin
      s1_d      = '0;
      s1_d.drop = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: 17-bit sums and three-way minimum
  // --------------------------------------------------------------------------
  i46_s2_t         s2_d, s2_q;
  logic [SLOT_W:0] pkt_sum, m4_sum, m6_ext, min_a, min_b;

  assign pkt_sum = {1'b0, s1_q.pkt} + IPV4_HDR_LEN;
  assign m4_sum  = {1'b0, s1_q.m4} + IPV4_HDR_LEN;
  assign m6_ext  = {1'b0, s1_q.m6};
  assign min_a   = (pkt_sum < m6_ext) ? pkt_sum : m6_ext;
  assign min_b   = (m4_sum < min_a) ? m4_sum : min_a;

  always_comb begin
    s2_d.drop   = s1_q.drop;
    s2_d.is_err = s1_q.is_err;
    s2_d.t6     = s1_q.t6;
    s2_d.c6     = s1_q.c6;
    s2_d.r6     = s1_q.r6;
    s2_d.is_mtu = s1_q.is_mtu;
    // bounded by the outgoing link MTU, so 16 bits hold it
    s2_d.mtu    = min_b[SLOT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      s2_q <= s2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: minimum MTU floor and output register
  // --------------------------------------------------------------------------
  i46_s3_t           s3_d, s3_q;
  logic [SLOT_W-1:0] mtu_fl;

  assign mtu_fl = (raise_q && (s2_q.mtu < MIN_MTU6)) ? MIN_MTU6 : s2_q.mtu;

  always_comb begin
    s3_d.verdict          = s2_q.drop;
    s3_d.is_error_message = s2_q.is_err;
    s3_d.msg6_type        = s2_q.t6;
    s3_d.msg6_code        = s2_q.c6;
    s3_d.icmp6_rest       = s2_q.is_mtu ? {16'b0, mtu_fl} : s2_q.r6;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      s3_q <= s3_d;
    end
  end

  assign out_o.valid            = v3_q;
  assign out_o.verdict          = s3_q.verdict;
  assign out_o.is_error_message = s3_q.is_error_message;
  assign out_o.msg6_type        = s3_q.msg6_type;
  assign out_o.msg6_code        = s3_q.msg6_code;
  assign out_o.icmp6_rest       = s3_q.icmp6_rest;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `I46_ASSERT_IMP(a_drop_clean, v3_q && s3_q.verdict,
                  !s3_q.is_error_message && s3_q.msg6_type == '0 &&
                  s3_q.msg6_code == '0 && s3_q.icmp6_rest == '0)
  `I46_ASSERT_IMP(a_mtu_narrow,
                  v3_q && !s3_q.verdict && s3_q.msg6_type == ICMP6_PKT_TOO_BIG,
                  s3_q.icmp6_rest[31:16] == '0)
  `I46_ASSERT_NXT(a_accept_fill, in_fire, v1_q)
  `I46_ASSERT_NXT(a_s2_hold, v2_q && !rdy3, v2_q && v3_q)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ICMPv4 to ICMPv6 header translator: a local
// predictor computes each translated header as it is accepted, and every
// output word is compared field by field in order. Directed headers cover
// the message mappings and MTU corner cases, then random traffic runs under
// several plateau and floor settings, mostly with random gaps on either side.
// ----------------------------------------------------------------------------
module tb
  import i46_pkg::*;
();

  localparam logic [7:0] ICMP4_UNKNOWN   = 8'd255;
  localparam logic [7:0] UNR_UNUSED      = 8'd14;
  localparam logic [7:0] PP4_MISSING_OPT = 8'd1;
  localparam logic [7:0] PTR4_UNMAPPED   = 8'd4;
  localparam logic [7:0] PTR4_LAST       = 8'd19;
  localparam logic [7:0] PTB6_CODE       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int RANDOM_PHASES    = 5;
  localparam int ITEMS_PER_PHASE  = 100;

  // IPv4 header offset to IPv6 header offset
  localparam logic [7:0] PTR6_OFFSET [20] = '{
    8'd0, 8'd1, 8'd4, 8'd4,
    PTR_NONE, PTR_NONE, PTR_NONE, PTR_NONE,
    8'd7, 8'd6, PTR_NONE, PTR_NONE,
    8'd8, 8'd8, 8'd8, 8'd8,
    8'd24, 8'd24, 8'd24, 8'd24
  };

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [31:0] rest;
    logic [15:0] echo_id;
    logic [15:0] inner_len;
    logic [15:0] mtu6;
    logic [15:0] mtu4;
  } icmp4_hdr_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  i46_in_if  in_if ();
  i46_out_if out_if ();

  icmp4_to_icmp6_header_translate i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register shadow
  logic [63:0] plateau_grp [3];
  logic [3:0]  plateau_cnt;
  logic        raise_min;

  i46_s3_t pending_icmp6 [$];
  int      fail_count;
  int      headers_checked;
  int      drops_seen;
  int      too_big_seen;
  int      settings_used;
  bit      send_idle;
  bit      recv_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic i46_s3_t translate_header(input icmp4_hdr_t h);
    i46_s3_t     r;
    logic        drop;
    logic        found;
    logic [16:0] pkt;
    logic [16:0] link4;
    logic [16:0] best;
    logic [15:0] slot;
    logic [7:0]  ptr;
    int          n;
    int          i;
    r    = '0;
    drop = 1'b0;
    case (h.msg_type)
      ICMP4_ECHO_REQUEST, ICMP4_ECHO_REPLY: begin
        r.msg6_type = (h.msg_type == ICMP4_ECHO_REQUEST) ? ICMP6_ECHO_REQUEST
                                                         : ICMP6_ECHO_REPLY;
        r.icmp6_rest = {h.echo_id, h.rest[15:0]};
      end
      ICMP4_DEST_UNREACH: begin
        r.is_error_message = 1'b1;
        r.msg6_type        = ICMP6_DEST_UNREACH;
        case (h.msg_code)
          UNR_NET, UNR_HOST, UNR_SRC_ROUTE, UNR_NET_UNKNOWN, UNR_HOST_UNKNOWN,
          UNR_ISOLATED, UNR_NET_TOS, UNR_HOST_TOS: begin
            r.msg6_code = DU6_NO_ROUTE;
          end
          UNR_PROTOCOL: begin
            r.msg6_type  = ICMP6_PARAM_PROBLEM;
            r.msg6_code  = PP6_NEXT_HDR;
            r.icmp6_rest = {24'd0, PTR6_NEXT_HDR};
          end
          UNR_PORT: begin
            r.msg6_code = DU6_PORT;
          end
          UNR_FRAG_NEEDED: begin
            r.msg6_type = ICMP6_PKT_TOO_BIG;
            r.msg6_code = PTB6_CODE;
            // zero reported MTU: take the first plateau below the inner length
            pkt   = {1'b0, h.rest[15:0]};
            found = 1'b0;
            n     = (int'(plateau_cnt) > PLATEAU_SLOTS_DEF) ? PLATEAU_SLOTS_DEF
                                                           : int'(plateau_cnt);
            if (h.rest[15:0] == '0) begin
              for (i = 0; i < n; i++) begin
                slot = plateau_grp[i / 4][(i % 4) * 16 +: 16];
                if (!found && slot < h.inner_len) begin
                  pkt   = {1'b0, slot};
                  found = 1'b1;
                end
              end
            end
            pkt   = pkt + IPV4_HDR_LEN;
            link4 = {1'b0, h.mtu4} + IPV4_HDR_LEN;
            best  = {1'b0, h.mtu6};
            if (pkt < best) best = pkt;
            if (link4 < best) best = link4;
            if (raise_min && best < {1'b0, MIN_MTU6}) best = {1'b0, MIN_MTU6};
            r.icmp6_rest = {15'd0, best};
          end
          UNR_NET_PROHIB, UNR_HOST_PROHIB, UNR_ADMIN_PROHIB, UNR_PREC_CUTOFF: begin
            r.msg6_code = DU6_ADMIN_PROHIB;
          end
          default: drop = 1'b1;
        endcase
      end
      ICMP4_TIME_EXCEEDED: begin
        r.is_error_message = 1'b1;
        r.msg6_type        = ICMP6_TIME_EXCEEDED;
        r.msg6_code        = h.msg_code;
      end
      ICMP4_PARAM_PROBLEM: begin
        r.is_error_message = 1'b1;
        r.msg6_type        = ICMP6_PARAM_PROBLEM;
        ptr                = h.rest[31:24];
        if (h.msg_code != PP4_POINTER && h.msg_code != PP4_BAD_LENGTH) begin
          drop = 1'b1;
        end else if (ptr > PTR4_LAST) begin
          drop = 1'b1;
        end else if (PTR6_OFFSET[ptr] == PTR_NONE) begin
          drop = 1'b1;
        end else begin
          r.msg6_code  = PP6_HDR_FIELD;
          r.icmp6_rest = {24'd0, PTR6_OFFSET[ptr]};
        end
      end
      default: drop = 1'b1;
    endcase
    if (drop) begin
      r         = '0;
      r.verdict = 1'b1;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Predict on input words, check on output words
  always @(posedge clk_i) begin
    i46_s3_t exp_hdr;
    i46_s3_t got;
    icmp4_hdr_t h;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        h = '{in_if.icmp4_type, in_if.icmp4_code, in_if.icmp4_rest, in_if.echo_identifier,
              in_if.inner_total_length, in_if.out_link_mtu, in_if.in_link_mtu};
        pending_icmp6.push_back(translate_header(h));
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.verdict, out_if.is_error_message, out_if.msg6_type,
                out_if.msg6_code, out_if.icmp6_rest};
        if (pending_icmp6.size() == 0) begin
          $error("unexpected output word: %0h", got);
          fail_count++;
        end else begin
          exp_hdr = pending_icmp6.pop_front();
          compare_field("verdict", 32'(exp_hdr.verdict), 32'(got.verdict));
          compare_field("is_error_message", 32'(exp_hdr.is_error_message),
                        32'(got.is_error_message));
          compare_field("msg6_type", 32'(exp_hdr.msg6_type), 32'(got.msg6_type));
          compare_field("msg6_code", 32'(exp_hdr.msg6_code), 32'(got.msg6_code));
          compare_field("icmp6_rest", exp_hdr.icmp6_rest, got.icmp6_rest);
          headers_checked++;
          if (exp_hdr.verdict) drops_seen++;
          if (!exp_hdr.verdict && exp_hdr.msg6_type == ICMP6_PKT_TOO_BIG) too_big_seen++;
        end
      end
    end
  end

  // Output side: if recv_idle, stall a random number of cycles before each word
  initial begin
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  function automatic icmp4_hdr_t make_header(input logic [7:0] t, input logic [7:0] c,
                                             input logic [31:0] rest,
                                             input logic [15:0] id, input logic [15:0] tot,
                                             input logic [15:0] m6, input logic [15:0] m4);
    icmp4_hdr_t h;
    h = '{t, c, rest, id, tot, m6, m4};
    return h;
  endfunction

  // Returns at the edge that accepts the word; valid stays high until the
  // next word or a drain lowers it.
  task automatic send_header(input icmp4_hdr_t h);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.icmp4_type         = h.msg_type;
    in_if.icmp4_code         = h.msg_code;
    in_if.icmp4_rest         = h.rest;
    in_if.echo_identifier    = h.echo_id;
    in_if.inner_total_length = h.inner_len;
    in_if.out_link_mtu       = h.mtu6;
    in_if.in_link_mtu        = h.mtu4;
    in_if.valid              = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_icmp6.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_PLATEAU_A: plateau_grp[0] = data;
      CFG_PLATEAU_B: plateau_grp[1] = data;
      CFG_PLATEAU_C: plateau_grp[2] = data;
      CFG_PLATEAU_N: plateau_cnt    = data[3:0];
      CFG_RAISE_MIN: raise_min      = data[0];
      default: ;
    endcase
  endtask

  task automatic test_echo();
    send_header(make_header(ICMP4_ECHO_REQUEST, 8'h00, 32'hFFFF_FFFF, 16'hFFFF,
                            16'h0000, 16'h0000, 16'h0000));
    send_header(make_header(ICMP4_ECHO_REPLY, 8'hFF, 32'h0000_0000, 16'h0000,
                            16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_unreachable();
    logic [7:0] codes [6];
    codes = '{UNR_NET, UNR_PROTOCOL, UNR_PORT, UNR_NET_PROHIB, UNR_UNUSED, 8'hFF};
    foreach (codes[k])
      send_header(make_header(ICMP4_DEST_UNREACH, codes[k], $urandom, 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  task automatic test_time_exceeded();
    send_header(make_header(ICMP4_TIME_EXCEEDED, 8'h00, $urandom, 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom)));
    send_header(make_header(ICMP4_TIME_EXCEEDED, 8'hFF, $urandom, 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  task automatic test_param_problem();
    send_header(make_header(ICMP4_PARAM_PROBLEM, PP4_POINTER, 32'h00FF_FFFF, 16'd0,
                            16'd0, 16'd0, 16'd0));
    send_header(make_header(ICMP4_PARAM_PROBLEM, PP4_BAD_LENGTH, {PTR4_LAST, 24'h0},
                            16'd0, 16'd0, 16'd0, 16'd0));
    // unmapped table entry, pointer past the table, unsupported code
    send_header(make_header(ICMP4_PARAM_PROBLEM, PP4_POINTER, {PTR4_UNMAPPED, 24'h0},
                            16'd0, 16'd0, 16'd0, 16'd0));
    send_header(make_header(ICMP4_PARAM_PROBLEM, PP4_POINTER, {PTR4_LAST + 8'd1, 24'h0},
                            16'd0, 16'd0, 16'd0, 16'd0));
    send_header(make_header(ICMP4_PARAM_PROBLEM, PP4_MISSING_OPT, 32'h0, 16'd0,
                            16'd0, 16'd0, 16'd0));
    send_header(make_header(ICMP4_UNKNOWN, 8'h00, 32'h0, 16'd0, 16'd0, 16'd0, 16'd0));
  endtask

  task automatic test_packet_too_big();
    logic [63:0] data;
    // no plateaus in use: zero MTU stays zero, then the floor applies
    send_header(make_header(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'h0, 16'd0,
                            16'd1500, 16'hFFFF, 16'hFFFF));
    // widest sums must not wrap
    send_header(make_header(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'h0000_FFFF, 16'd0,
                            16'd0, 16'hFFFF, 16'hFFFF));
    send_header(make_header(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'd1000, 16'd0,
                            16'd0, 16'd9000, 16'd1500));
    write_config(CFG_RAISE_MIN, 64'hFFFF_FFFF_FFFF_FFFE);
    settings_used++;
    send_header(make_header(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'd1000, 16'd0,
                            16'd0, 16'd9000, 16'd1500));
    write_config(CFG_PLATEAU_A, {16'd2002, 16'd4352, 16'd8166, 16'd17914});
    write_config(CFG_PLATEAU_B, {16'd296, 16'd508, 16'd1006, 16'd1492});
    write_config(CFG_PLATEAU_C, {16'd0, 16'd0, 16'd0, 16'd68});
    write_config(CFG_PLATEAU_N, 64'd12);
    settings_used++;
    send_header(make_header(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'h0, 16'd0,
                            16'd1500, 16'hFFFF, 16'hFFFF));
    // inner length zero: no plateau qualifies
    send_header(make_header(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'h0, 16'd0,
                            16'd0, 16'hFFFF, 16'hFFFF));
    // count above the slot number saturates; spare indexes are ignored
    data = {$urandom, $urandom};
    data[3:0] = 4'hF;
    write_config(CFG_PLATEAU_N, data);
    write_config(CFG_SPARE_LO, {$urandom, $urandom});
    write_config(CFG_SPARE_HI, {$urandom, $urandom});
    settings_used++;
    send_header(make_header(ICMP4_DEST_UNREACH, UNR_FRAG_NEEDED, 32'hFFFF_0000, 16'd0,
                            16'd50, 16'hFFFF, 16'hFFFF));
  endtask

  function automatic icmp4_hdr_t random_header();
    icmp4_hdr_t h;
    int sel;
    h   = icmp4_hdr_t'({$urandom, $urandom, $urandom, 16'($urandom)});
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      h.mtu6      = 16'($urandom_range(1200, 9000));
      h.mtu4      = 16'($urandom_range(500, 9000));
      h.inner_len = 16'($urandom_range(20, 9000));
    end
    if (sel < 12) begin
      h.msg_type = ICMP4_ECHO_REQUEST;
    end else if (sel < 24) begin
      h.msg_type = ICMP4_ECHO_REPLY;
    end else if (sel < 60) begin
      h.msg_type = ICMP4_DEST_UNREACH;
      case ($urandom_range(0, 9))
        0:       ;
        1, 2, 3: h.msg_code = 8'($urandom_range(0, 15));
        default: h.msg_code = UNR_FRAG_NEEDED;
      endcase
      if (h.msg_code == UNR_FRAG_NEEDED && $urandom_range(0, 1) == 0) h.rest[15:0] = '0;
    end else if (sel < 70) begin
      h.msg_type = ICMP4_TIME_EXCEEDED;
      if ($urandom_range(0, 3) != 0) h.msg_code = 8'($urandom_range(0, 1));
    end else if (sel < 90) begin
      h.msg_type = ICMP4_PARAM_PROBLEM;
      if ($urandom_range(0, 4) != 0)
        h.msg_code = $urandom_range(0, 1) ? PP4_POINTER : PP4_BAD_LENGTH;
      if ($urandom_range(0, 6) != 0) h.rest[31:24] = 8'($urandom_range(0, PTR4_LAST));
    end
    return h;
  endfunction

  task automatic test_random_traffic();
    logic [63:0] grp;
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        raise;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int g = 0; g < 3; g++) begin
        for (int s = 0; s < 4; s++)
          grp[s * 16 +: 16] = $urandom_range(0, 1) ? 16'($urandom_range(68, 17914))
                                                   : 16'($urandom_range(0, 65535));
        write_config(CFG_PLATEAU_A + CFG_IDX_W'(g), grp);
      end
      case (p)
        0:       begin cnt = 4'd12; raise = 1'b1; end
        1:       begin cnt = 4'd0;  raise = 1'b0; end
        3:       begin cnt = 4'hF;  raise = 1'b0; end
        default: begin
          cnt   = 4'($urandom_range(0, 15));
          raise = 1'($urandom_range(0, 1));
        end
      endcase
      data = {$urandom, $urandom};
      data[3:0] = cnt;
      write_config(CFG_PLATEAU_N, data);
      data = {$urandom, $urandom};
      data[0] = raise;
      write_config(CFG_RAISE_MIN, data);
      settings_used++;
      send_idle = (p % 2 == 0) || (p == 4);
      recv_idle = (p < 3);
      repeat (ITEMS_PER_PHASE) send_header(random_header());
    end
  endtask

  initial begin : main
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_PLATEAU_A;
    cfg_data_i  = '0;
    in_if.valid = 1'b0;
    in_if.icmp4_type         = '0;
    in_if.icmp4_code         = '0;
    in_if.icmp4_rest         = '0;
    in_if.echo_identifier    = '0;
    in_if.inner_total_length = '0;
    in_if.out_link_mtu       = '0;
    in_if.in_link_mtu        = '0;
    plateau_grp  = '{64'd0, 64'd0, 64'd0};
    plateau_cnt  = '0;
    raise_min    = 1'b1;
    fail_count   = 0;
    headers_checked = 0;
    drops_seen   = 0;
    too_big_seen = 0;
    settings_used = 1;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_echo();
    test_unreachable();
    test_time_exceeded();
    test_param_problem();
    test_packet_too_big();
    test_random_traffic();

    // drain the pipeline, bounded
    @(negedge clk_i);
    in_if.valid = 1'b0;
    for (int k = 0; k < 2000 && pending_icmp6.size() != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_icmp6.size() != 0) begin
      $error("%0d translated headers never arrived", pending_icmp6.size());
      fail_count++;
    end

    $display("checked %0d translated headers (%0d dropped, %0d packet-too-big)",
             headers_checked, drops_seen, too_big_seen);
    $display("across %0d register settings, with and without idle cycles",
             settings_used);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- icmp4_to_icmp6_header_translate.f -----
+incdir+rtl/core
rtl/core/i46_pkg.sv
rtl/core/i46_in_if.sv
rtl/core/i46_out_if.sv
rtl/core/i46_plateau_search.sv
rtl/core/icmp4_to_icmp6_header_translate.sv
sim/tb.sv
